// File: design/antialiased_circle_fill_defines.svh
// assertion macros shared by the circle fill design
`ifndef ANTIALIASED_CIRCLE_FILL_DEFINES_SVH
`define ANTIALIASED_CIRCLE_FILL_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked check, quiet while reset is low
`define ACF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ACF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ACF_ASSERT(lbl, prop, msg)
`define ACF_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: design/acf_pkg.sv
package acf_pkg;

    // framebuffer bounds
    localparam int FRAME_COLS = 1024;
    localparam int FRAME_ROWS = 1024;

    // signed width of a centre-to-pixel distance in whole pixels
    localparam int CW = 13;

    // channel full scale
    localparam logic [7:0] CH_MAX = 8'd255;

    // divide by 255 as multiply and shift, exact for values below 65536
    localparam int          DIV255_SHIFT = 24;
    localparam logic [16:0] DIV255_MUL   = 17'd65794;

    // shift used for the weight reciprocal
    localparam int RECIP_K = 24;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILL_COLOR = 3'd0,
        CFG_OPACITY    = 3'd1,
        CFG_RADIUS     = 3'd2,
        CFG_CENTER_X   = 3'd3,
        CFG_CENTER_Y   = 3'd4
    } t_cfg_idx;

endpackage

// File: design/antialiased_circle_fill.sv
// throughput: one item per cycle unless stalled, nine-stage register pipeline
// each stage holds its item while the stage after it is full and stalled
// reset (i_rst_n low at a clock edge) empties the pipeline and loads the
// configuration registers with their defaults; no memory, no clearing pass
`include "antialiased_circle_fill_defines.svh"

module antialiased_circle_fill
    import acf_pkg::*;
#(
    parameter int SUBSAMPLES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // pixel in
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // pixel_x, pixel_y, dest_blue, dest_green, dest_red, dest_alpha, zero pad
    input  logic [55:0]          i_s_tdata,
    // pixel out
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // out_blue, out_green, out_red, out_alpha
    output logic [31:0]          o_m_tdata,
    // write_pixel
    output logic [0:0]           o_m_tuser
);

    localparam int NSTG    = 9;
    localparam int SCALE   = 2 * SUBSAMPLES;
    localparam int SC_LOG  = $clog2(SCALE);
    localparam int SX_W    = CW + SC_LOG;
    localparam int SQ_W    = 2 * SX_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int SR_W    = 10 + SC_LOG;
    localparam int LIM_W   = 2 * SR_W;
    localparam int D2_W    = 2 * CW;
    localparam int NSUB    = SUBSAMPLES * SUBSAMPLES;
    localparam int CNT_W   = $clog2(NSUB + 1);
    localparam int PROD_W  = 8 + CNT_W;
    localparam int RECIP_W = 25;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int MIX_W   = 16;
    localparam int DIVM_W  = MIX_W + 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_K + NSUB - 1) / NSUB);

    // configuration registers
    logic [31:0] r_fill_color;
    logic [7:0]  r_opacity;
    logic [9:0]  r_radius;
    logic [11:0] r_center_x;
    logic [11:0] r_center_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= '0;
            r_opacity    <= CH_MAX;
            r_radius     <= '0;
            r_center_x   <= '0;
            r_center_y   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FILL_COLOR: r_fill_color <= i_cfg_data;
                CFG_OPACITY:    r_opacity    <= i_cfg_data[7:0];
                CFG_RADIUS:     r_radius     <= i_cfg_data[9:0];
                CFG_CENTER_X:   r_center_x   <= i_cfg_data[11:0];
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] stg_en;

    assign stg_en[NSTG-1] = !r_v[NSTG-1] || i_m_tready;

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign stg_en[k] = !r_v[k] || stg_en[k+1];
    end

    assign o_s_tready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: distances to the centre, radius terms
    logic [9:0]              in_px;
    logic [9:0]              in_py;
    logic signed [CW-1:0]    r1_dx;
    logic signed [CW-1:0]    r1_dy;
    logic                    r1_infb;
    logic [9:0]              r1_rm1;
    logic [10:0]             r1_rp1;
    logic                    r1_rnz;
    logic [SR_W-1:0]         r1_sr;
    logic [31:0]             r1_dest;

    assign in_px = i_s_tdata[9:0];
    assign in_py = i_s_tdata[19:10];

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r1_dx   <= $signed({3'b000, in_px}) - $signed({r_center_x[11], r_center_x});
            r1_dy   <= $signed({3'b000, in_py}) - $signed({r_center_y[11], r_center_y});
            r1_infb <= (CW'(in_px) < CW'(FRAME_COLS)) && (CW'(in_py) < CW'(FRAME_ROWS));
            r1_rm1  <= r_radius - 10'd1;
            r1_rp1  <= 11'(r_radius) + 11'd1;
            r1_rnz  <= r_radius != 10'd0;
            r1_sr   <= SR_W'(r_radius) * SR_W'(SCALE);
            r1_dest <= i_s_tdata[51:20];
        end
    end

    // stage 2: whole-pixel squares, subsample offsets, zone limits
    logic [D2_W-1:0]         r2_dx2;
    logic [D2_W-1:0]         r2_dy2;
    logic signed [SX_W-1:0]  r2_sx [SUBSAMPLES];
    logic signed [SX_W-1:0]  r2_sy [SUBSAMPLES];
    logic [19:0]             r2_lo;
    logic [21:0]             r2_hi;
    logic [LIM_W-1:0]        r2_lim;
    logic                    r2_rnz;
    logic                    r2_infb;
    logic [31:0]             r2_dest;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r2_dx2  <= D2_W'(r1_dx * r1_dx);
            r2_dy2  <= D2_W'(r1_dy * r1_dy);
            r2_lo   <= 20'(r1_rm1) * 20'(r1_rm1);
            r2_hi   <= 22'(r1_rp1) * 22'(r1_rp1);
            r2_lim  <= LIM_W'(r1_sr) * LIM_W'(r1_sr);
            r2_rnz  <= r1_rnz;
            r2_infb <= r1_infb;
            r2_dest <= r1_dest;
        end
    end

    // one lane per subsample row and column
    for (genvar i = 0; i < SUBSAMPLES; i++) begin : g_off
        always_ff @(posedge i_clk) begin
            if (stg_en[1]) begin
                r2_sx[i] <= SX_W'(r1_dx) * SX_W'(SCALE) + SX_W'(2 * i + 1);
                r2_sy[i] <= SX_W'(r1_dy) * SX_W'(SCALE) + SX_W'(2 * i + 1);
            end
        end
    end

    // stage 3: squared distance and subsample squares
    logic [D2_W-1:0]         r3_d2;
    logic [SQ_W-1:0]         r3_sx2 [SUBSAMPLES];
    logic [SQ_W-1:0]         r3_sy2 [SUBSAMPLES];
    logic [19:0]             r3_lo;
    logic [21:0]             r3_hi;
    logic [LIM_W-1:0]        r3_lim;
    logic                    r3_rnz;
    logic                    r3_infb;
    logic [31:0]             r3_dest;

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r3_d2   <= r2_dx2 + r2_dy2;
            r3_lo   <= r2_lo;
            r3_hi   <= r2_hi;
            r3_lim  <= r2_lim;
            r3_rnz  <= r2_rnz;
            r3_infb <= r2_infb;
            r3_dest <= r2_dest;
        end
    end

    for (genvar i = 0; i < SUBSAMPLES; i++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (stg_en[2]) begin
                r3_sx2[i] <= $unsigned(SQ_W'(r2_sx[i] * r2_sx[i]));
                r3_sy2[i] <= $unsigned(SQ_W'(r2_sy[i] * r2_sy[i]));
            end
        end
    end

    // stage 4: zone tests and subsample inside bits
    logic                    r4_full;
    logic                    r4_edge;
    logic [NSUB-1:0]         r4_hit;
    logic [31:0]             r4_dest;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r4_full <= r3_infb && r3_rnz && (r3_d2 <= D2_W'(r3_lo));
            r4_edge <= r3_infb && (r3_d2 <= D2_W'(r3_hi));
            r4_dest <= r3_dest;
        end
    end

    for (genvar i = 0; i < SUBSAMPLES; i++) begin : g_hx
        for (genvar j = 0; j < SUBSAMPLES; j++) begin : g_hy
            always_ff @(posedge i_clk) begin
                if (stg_en[3]) begin
                    r4_hit[i*SUBSAMPLES+j] <=
                        ({1'b0, r3_sx2[i]} + {1'b0, r3_sy2[j]}) <= SUM_W'(r3_lim);
                end
            end
        end
    end

    // stage 5: subsample count
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        r5_count;
    logic                    r5_full;
    logic                    r5_edge;
    logic [31:0]             r5_dest;

    always_comb begin
        n_count = '0;
        for (int k = 0; k < NSUB; k++) begin
            n_count = n_count + CNT_W'(r4_hit[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r5_count <= n_count;
            r5_full  <= r4_full;
            r5_edge  <= r4_edge;
            r5_dest  <= r4_dest;
        end
    end

    // stage 6: write decision and opacity times coverage
    // the full zone counts as every subsample inside, giving opacity exactly
    logic [CNT_W-1:0]        n_cov;
    logic [PROD_W-1:0]       r6_prod;
    logic                    r6_write;
    logic [31:0]             r6_dest;

    assign n_cov = r5_full ? CNT_W'(NSUB) : r5_count;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r6_prod  <= PROD_W'(r_opacity) * PROD_W'(n_cov);
            r6_write <= r5_full || (r5_edge && (r5_count != '0));
            r6_dest  <= r5_dest;
        end
    end

    // stage 7: weight = product / subsample total, by reciprocal
    logic [MUL_W-1:0]        n_wprod;
    logic [7:0]              r7_w;
    logic                    r7_write;
    logic [31:0]             r7_dest;

    assign n_wprod = MUL_W'(r6_prod) * MUL_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r7_w     <= n_wprod[RECIP_K +: 8];
            r7_write <= r6_write;
            r7_dest  <= r6_dest;
        end
    end

    // stage 8: weighted channel sums
    logic [7:0]              n_winv;
    logic [MIX_W-1:0]        r8_mix [4];
    logic                    r8_bypass;
    logic                    r8_write;
    logic [31:0]             r8_dest;

    assign n_winv = CH_MAX - r7_w;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            for (int c = 0; c < 4; c++) begin
                r8_mix[c] <= MIX_W'(r_fill_color[8*c +: 8]) * MIX_W'(r7_w)
                           + MIX_W'(r7_dest[8*c +: 8]) * MIX_W'(n_winv);
            end
            r8_bypass <= r7_w == CH_MAX;
            r8_write  <= r7_write;
            r8_dest   <= r7_dest;
        end
    end

    // stage 9: divide by 255, color bypass at full weight, output register
    logic [DIVM_W-1:0]       n_divp [4];
    logic [31:0]             n_pix;
    logic [31:0]             r9_data;
    logic                    r9_write;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_divp[c] = DIVM_W'(r8_mix[c]) * DIVM_W'(DIV255_MUL);
            if (r8_bypass && c < 3) begin
                n_pix[8*c +: 8] = r_fill_color[8*c +: 8];
            end else begin
                n_pix[8*c +: 8] = n_divp[c][DIV255_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r9_data  <= r8_write ? n_pix : r8_dest;
            r9_write <= r8_write;
        end
    end

    assign o_m_tvalid   = r_v[NSTG-1];
    assign o_m_tdata    = r9_data;
    assign o_m_tuser[0] = r9_write;

    // checks
    `ACF_ASSERT_RST(a_rst_flush, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")
    `ACF_ASSERT(a_full_in_edge, r_v[3] && r4_full |-> r4_edge, "full zone outside edge limit")
    `ACF_ASSERT(a_count_max, r_v[4] |-> r5_count <= CNT_W'(NSUB), "subsample count overflow")
    `ACF_ASSERT(a_no_drop, r_v[7] && stg_en[7] |=> r_v[8], "item lost before output stage")

endmodule
